/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/ght_pkg.sv */
// ----------------------------------------------------------------------------
// ght_pkg
// Types and constants of the generational handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

  // Width of an incarnation and of a slot index on the request.
  localparam int unsigned IncW  = 32;
  localparam int unsigned SlotW = 32;
  // Width of the occupied count and of the max_slots register.
  localparam int unsigned CntW  = 11;
  localparam int unsigned ModeW = 3;

  // Reset value of the max_slots register.
  localparam logic [CntW-1:0] MaxSlotsReset = 11'd1024;
  // Reset value of the next-incarnation counter.
  localparam logic [IncW-1:0] NextIssueReset = 32'd1;

  // Request modes; code 7 is unused and falls to the default arm.
  typedef enum logic [ModeW-1:0] {
    MODE_ISSUE    = 3'd0,
    MODE_MERGE    = 3'd1,
    MODE_ACTIVATE = 3'd2,
    MODE_RELEASE  = 3'd3,
    MODE_CONTAINS = 3'd4,
    MODE_IDENTITY = 3'd5,
    MODE_CLEAR    = 3'd6
  } mode_e;

  // Control states of the table sequencer.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

endpackage

`default_nettype wire

/* rtl/ght_ram.sv */
// ----------------------------------------------------------------------------
// ght_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/generational_handle_table_unit.sv */
// ----------------------------------------------------------------------------
// generational_handle_table_unit
// Table of slot incarnations with issue, merge, activate, release, lookup and
// clear requests, plus an occupied count and a next-incarnation counter.
// ----------------------------------------------------------------------------
// The table lives in one RAM of SLOTS 32-bit entries with a registered
// read. A request is taken in one cycle, which starts the table read, and is
// executed in the next, or later while the result register is still held by
// the downstream side; execution writes the entry back and loads the result
// register, and no new request is taken before it. After reset and after
// every clear request the block sweeps the RAM, one entry a cycle, over all
// SLOTS entries (1024 by default); during that pass no request is taken,
// while configuration writes are taken as always. The clear result itself is
// delivered at the start of the pass.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table_unit
  import ght_pkg::*;
#(
  parameter int unsigned SLOTS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: max_slots.
  input  wire logic        cfg_we_i,
  input  wire logic [10:0] cfg_wdata_i,
  // Request stream.
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [63:0] s_tdata_i,   // slot [31:0], incarnation [63:32]
  input  wire logic [2:0]  s_tuser_i,   // mode [2:0]
  // Result stream.
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic      [47:0] m_tdata_o,   // value [31:0], active_count [42:32], zero
  output logic      [0:0]  m_tuser_o    // ok [0]
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SlotW-1:0] SlotsVal = SlotW'(SLOTS);
  localparam logic [AW-1:0]    LastAddr = AW'(SLOTS - 1);

  // Control and architectural state.
  state_e            state_q, state_d;
  logic [AW-1:0]     sweep_q, sweep_d;
  logic [CntW-1:0]   max_slots_q;
  logic [IncW-1:0]   next_q, next_d;
  logic [CntW-1:0]   count_q, count_d;

  // Request held during execution.
  mode_e             req_mode_q;
  logic [SlotW-1:0]  req_slot_q;
  logic [IncW-1:0]   req_inc_q;

  // Result register.
  logic              m_valid_q, m_valid_d;
  logic              m_ok_q, m_ok_d;
  logic [IncW-1:0]   m_value_q, m_value_d;
  logic [CntW-1:0]   m_count_q, m_count_d;

  // Table RAM signals.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [IncW-1:0]   ram_wdata;
  logic              ram_re;
  logic [IncW-1:0]   ram_rdata;

  logic              in_accept;
  logic              out_free;
  logic              commit;

  assign s_tready_o = (state_q == S_IDLE);
  assign in_accept  = s_tvalid_i && s_tready_o;
  assign out_free   = !m_valid_q || m_tready_i;
  assign commit     = (state_q == S_EXEC) && out_free;

  assign ram_re = in_accept;

  ght_ram #(
    .WIDTH (IncW),
    .DEPTH (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (s_tdata_i[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    unique case (state_q)
      S_CLEAR: begin
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          if (req_mode_q == MODE_CLEAR) begin
            state_d = S_CLEAR;
            sweep_d = '0;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Request execution: read-modify-write of one entry and the result.
  always_comb begin
    logic            in_range;
    logic            in_limit;
    logic            present;
    logic [IncW-1:0] entry;

    entry    = ram_rdata;
    in_range = req_slot_q < SlotsVal;
    in_limit = in_range && (req_slot_q < {{(SlotW-CntW){1'b0}}, max_slots_q});
    present  = (req_inc_q != '0) && in_range && (entry == req_inc_q);

    next_d    = next_q;
    count_d   = count_q;
    m_valid_d = m_valid_q && !m_tready_i;
    m_ok_d    = m_ok_q;
    m_value_d = m_value_q;
    m_count_d = m_count_q;
    ram_we    = 1'b0;
    ram_waddr = req_slot_q[AW-1:0];
    ram_wdata = '0;

    if (state_q == S_CLEAR) begin
      // Clearing pass writes zero to one entry a cycle.
      ram_we    = 1'b1;
      ram_waddr = sweep_q;
    end else if (commit) begin
      m_valid_d = 1'b1;
      m_ok_d    = 1'b0;
      m_value_d = '0;
      unique case (req_mode_q)
        MODE_ISSUE: begin
          m_value_d = next_q;
          m_ok_d    = (next_q != '0);
          // Stepping past the top wraps to zero, which sticks.
          next_d    = next_q + IncW'(next_q != '0);
        end
        MODE_MERGE: begin
          m_ok_d = 1'b1;
          if ((next_q == '0) || (req_inc_q == '0)) begin
            next_d = '0;
          end else if (req_inc_q > next_q) begin
            next_d = req_inc_q;
          end
        end
        MODE_ACTIVATE: begin
          if ((req_inc_q != '0) && in_limit) begin
            m_ok_d    = 1'b1;
            ram_we    = 1'b1;
            ram_wdata = req_inc_q;
            count_d   = count_q + CntW'(entry == '0);
            if ((next_q != '0) && (req_inc_q >= next_q)) begin
              next_d = req_inc_q + IncW'(1);
            end
          end
        end
        MODE_RELEASE: begin
          if (present) begin
            m_ok_d  = 1'b1;
            ram_we  = 1'b1;
            count_d = count_q - CntW'(1);
          end
        end
        MODE_CONTAINS: begin
          m_ok_d = present;
        end
        MODE_IDENTITY: begin
          if (in_range) begin
            m_value_d = entry;
            m_ok_d    = (entry != '0);
          end
        end
        MODE_CLEAR: begin
          m_ok_d  = 1'b1;
          count_d = '0;
        end
        default: begin
          m_ok_d = 1'b0;
        end
      endcase
      m_count_d = count_d;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      sweep_q     <= '0;
      max_slots_q <= MaxSlotsReset;
      next_q      <= NextIssueReset;
      count_q     <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_q   <= sweep_d;
      next_q    <= next_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        max_slots_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_mode_q <= mode_e'(s_tuser_i);
      req_slot_q <= s_tdata_i[31:0];
      req_inc_q  <= s_tdata_i[63:32];
    end
    m_ok_q    <= m_ok_d;
    m_value_q <= m_value_d;
    m_count_q <= m_count_d;
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = {5'd0, m_count_q, m_value_q};
  assign m_tuser_o  = m_ok_q;

  // Assertions.
  `include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_exec, clk_i, rst_ni, in_accept, state_q == S_EXEC)
  `ASSERT_IMPLY(a_no_write_idle, clk_i, rst_ni, state_q == S_IDLE, !ram_we)
  `ASSERT_IMPLY(a_result_from_exec, clk_i, rst_ni, $rose(m_tvalid_o), $past(state_q) == S_EXEC)
  `ASSERT_NEXT(a_clear_zero_count, clk_i, rst_ni, commit && (req_mode_q == MODE_CLEAR), count_q == '0)

endmodule

`default_nettype wire
